// File: rtl/alr_pkg.sv
`default_nettype none

package alr_pkg;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 24;

    localparam logic [CFG_AW-1:0] CFG_PLAYBACK_RATE     = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_TRIGGER_CONNECTED = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_TRIGGER_LEVEL     = 2'd2;

    localparam logic [CFG_DW-1:0] RATE_RESET = 24'h010000;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_red_stat;

endpackage

`default_nettype wire

// File: rtl/alr_ram.sv
`default_nettype none

module alr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// File: rtl/alr_rate_wrap.sv
`default_nettype none

// Reduces the playback step modulo span * 2^16 into the non-negative range,
// one conditional subtract per cycle.
module alr_rate_wrap #(
    parameter int AW = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [AW:0]             i_span,
    input  wire logic [alr_pkg::CFG_DW-1:0] i_rate,
    output alr_pkg::t_red_stat           o_stat,
    output logic [AW+alr_pkg::FRAC_W-1:0] o_step
);

    import alr_pkg::*;

    localparam int VW = AW + 10;

    logic [VW-1:0]     r_v,   n_v;
    logic [VW-1:0]     r_sub;
    logic [3:0]        r_cnt;
    logic [FRAC_W-1:0] r_frac;
    logic              r_busy;
    logic              r_done;
    logic [VW-1:0]     v_start;

    // integer part of the step plus 256 spans keeps the value non-negative
    assign v_start = {{(VW-8){i_rate[CFG_DW-1]}}, i_rate[CFG_DW-1:FRAC_W]}
                   + ({{(VW-AW-1){1'b0}}, i_span} << 8);

    assign n_v = (r_v >= r_sub) ? r_v - r_sub : r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 4'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= v_start;
            r_sub  <= {{(VW-AW-1){1'b0}}, i_span} << 8;
            r_cnt  <= 4'd8;
            r_frac <= i_rate[FRAC_W-1:0];
        end else if (r_busy) begin
            r_v   <= n_v;
            r_sub <= r_sub >> 1;
            r_cnt <= r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                o_step <= {n_v[AW-1:0], r_frac};
            end
        end
    end

    assign o_stat = {r_busy, r_done};

endmodule

`default_nettype wire

// File: rtl/audio_looper_record_play_top.sv
`default_nettype none

// Audio looper: a rising trigger toggles between recording a take into the
// sample store and playing it back at a signed fractional rate with linear
// interpolation. A recording item takes one write of the single-port store,
// a playing item two reads of the neighbouring samples one after the other,
// so items are accepted every cycle while recording unless a stall holds
// them off, and not during a playing item's second read. Results pass the
// st1, st2 and st3 registers into an eight-entry output queue, which lets
// input keep flowing while the output side stalls, until the queue and the
// stages fill. After reset the store is cleared over all BUFFER_DEPTH
// addresses; after a playback rate write and at the end of each take the
// step is reduced against the loop length; during both input is held off.
module audio_looper_record_play_top #(
    parameter int BUFFER_DEPTH = 65536
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [alr_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [alr_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [31:0]                s_axis_tdata,  // audio_in, trigger_in
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic      [15:0]                m_axis_tdata   // audio_out
);

    import alr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int HW = AW + FRAC_W;
    localparam int SW = AW + 1;

    typedef struct packed {
        logic              play;
        logic [FRAC_W-1:0] frac;
        logic [AW-1:0]     idx1;
    } t_st1;

    typedef struct packed {
        logic                play;
        logic [FRAC_W-1:0]   frac;
        logic [SAMPLE_W-1:0] s0;
    } t_st2;

    typedef struct packed {
        logic                play;
        logic [SAMPLE_W-1:0] s0;
        logic [33:0]         prod;
    } t_st3;

    // configuration
    logic [CFG_DW-1:0]   r_rate;
    logic                r_trig_conn;
    logic [SAMPLE_W-1:0] r_trig_lvl;

    // looper state
    logic          r_rec;
    logic          r_was_high;
    logic [HW-1:0] r_head;
    logic [AW-1:0] r_loop_end;
    logic          r_head_pend;
    logic          r_red_start;

    // store clearing
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // pipeline
    logic r_st1_v, r_st2_v, r_st3_v;
    t_st1 r_st1;
    t_st2 r_st2;
    t_st3 r_st3;

    // output queue
    logic [SAMPLE_W-1:0] r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]    r_fifo_cnt;

    logic [SAMPLE_W-1:0] audio_in, trig_in, trig;
    logic                high, rise, rec_new, acc;
    logic [HW-1:0]       head_base;
    logic [AW-1:0]       idx, idx1;
    logic [SW-1:0]       span;
    logic [HW:0]         span_fx, head_sum, head_wrap;
    logic [HW-1:0]       red_step;
    t_red_stat           red_stat;
    logic [FIFO_AW+1:0]  occ;

    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

    logic signed [16:0]  diff;
    logic signed [33:0]  prod, rnd;
    logic [17:0]         y18;
    logic [SAMPLE_W-1:0] res;
    logic                push, pop;

    assign audio_in = s_axis_tdata[15:0];
    assign trig_in  = s_axis_tdata[31:16];
    assign trig     = r_trig_conn ? trig_in : r_trig_lvl;
    assign high     = !trig[SAMPLE_W-1] && (|trig);
    assign rise     = !r_was_high && high;
    assign rec_new  = r_rec ^ rise;

    assign head_base = rise ? '0 : r_head;
    assign idx       = head_base[HW-1:FRAC_W];
    assign idx1      = (idx == AW'(BUFFER_DEPTH - 1)) ? '0 : idx + 1'b1;

    assign span      = (r_loop_end == '0) ? SW'(BUFFER_DEPTH) : {1'b0, r_loop_end};
    assign span_fx   = {span, {FRAC_W{1'b0}}};
    assign head_sum  = {1'b0, r_head} + {1'b0, red_step};
    assign head_wrap = (head_sum >= span_fx) ? head_sum - span_fx : head_sum;

    assign occ = {1'b0, r_fifo_cnt} + (FIFO_AW+2)'(r_st1_v) + (FIFO_AW+2)'(r_st2_v)
               + (FIFO_AW+2)'(r_st3_v);

    assign s_axis_tready = !r_clr_busy && !r_red_start && !red_stat.busy && !r_head_pend
                         && !(r_st1_v && r_st1.play) && (occ < (FIFO_AW+2)'(FIFO_DEPTH));
    assign acc = s_axis_tvalid && s_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= RATE_RESET;
            r_trig_conn <= 1'b0;
            r_trig_lvl  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PLAYBACK_RATE:     r_rate      <= i_cfg_wdata;
                CFG_TRIGGER_CONNECTED: r_trig_conn <= i_cfg_wdata[0];
                CFG_TRIGGER_LEVEL:     r_trig_lvl  <= i_cfg_wdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // looper state and step reduction requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec       <= 1'b0;
            r_was_high  <= 1'b0;
            r_head      <= '0;
            r_loop_end  <= '0;
            r_head_pend <= 1'b0;
            r_red_start <= 1'b1;
        end else begin
            r_red_start <= i_cfg_we && (i_cfg_addr == CFG_PLAYBACK_RATE);
            if (red_stat.done && r_head_pend) begin
                r_head      <= red_step;
                r_head_pend <= 1'b0;
            end
            if (acc) begin
                r_was_high <= high;
                r_rec      <= rec_new;
                if (rec_new) begin
                    r_head <= {idx1, {FRAC_W{1'b0}}};
                end else if (rise) begin
                    // end of take: new loop length, step must be reduced again
                    r_loop_end  <= r_head[HW-1:FRAC_W];
                    r_head      <= '0;
                    r_head_pend <= 1'b1;
                    r_red_start <= 1'b1;
                end else begin
                    r_head <= head_wrap[HW-1:0];
                end
            end
        end
    end

    alr_rate_wrap #(
        .AW (AW)
    ) u_rate_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_red_start),
        .i_span  (span),
        .i_rate  (r_rate),
        .o_stat  (red_stat),
        .o_step  (red_step)
    );

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(BUFFER_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = idx;
        ram_wdata = audio_in;
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_addr  = r_clr_addr;
            ram_wdata = '0;
        end else if (r_st1_v && r_st1.play) begin
            ram_addr = r_st1.idx1;
        end else if (acc) begin
            ram_we = rec_new;
        end
    end

    alr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // interpolation: s0 + f * (s1 - s0) / 2^16, rounded half up
    assign diff = $signed({ram_rdata[SAMPLE_W-1], ram_rdata})
                - $signed({r_st2.s0[SAMPLE_W-1], r_st2.s0});
    assign prod = $signed({1'b0, r_st2.frac}) * diff;
    assign rnd  = $signed(r_st3.prod) + 34'sd32768;
    assign y18  = {{2{r_st3.s0[SAMPLE_W-1]}}, r_st3.s0} + rnd[33:16];
    assign res  = r_st3.play ? y18[SAMPLE_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st1_v <= 1'b0;
            r_st2_v <= 1'b0;
            r_st3_v <= 1'b0;
        end else begin
            r_st1_v <= acc;
            r_st2_v <= r_st1_v;
            r_st3_v <= r_st2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st1.play <= !rec_new;
        r_st1.frac <= head_base[FRAC_W-1:0];
        r_st1.idx1 <= idx1;
        r_st2.play <= r_st1.play;
        r_st2.frac <= r_st1.frac;
        r_st2.s0   <= ram_rdata;
        r_st3.play <= r_st2.play;
        r_st3.s0   <= r_st2.s0;
        r_st3.prod <= prod;
    end

    // output queue
    assign push          = r_st3_v;
    assign m_axis_tvalid = (r_fifo_cnt != '0);
    assign m_axis_tdata  = r_fifo[r_rd_ptr];
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_fifo_cnt <= r_fifo_cnt + 1'b1;
                2'b01:   r_fifo_cnt <= r_fifo_cnt - 1'b1;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_on_second_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st1_v && r_st1.play) |-> !acc)
        else $error("item accepted while the second sample read is in flight");

    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_fifo_cnt < (FIFO_AW+1)'(FIFO_DEPTH)) || pop)
        else $error("result pushed into a full output queue");

    // the record head runs over the whole store, only the play head is bounded
    a_head_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_rec && !r_head_pend) |-> ({1'b0, r_head} < span_fx))
        else $error("head outside the wrap length");

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !acc)
        else $error("item accepted during the clearing pass");
`endif

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import alr_pkg::*;

    localparam int DEPTH       = 65536;
    localparam int IDLE_PCT    = 35;
    localparam int SETTLE      = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_MAX    = 10;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr    = '0;
    logic [CFG_DW-1:0] i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;

    audio_looper_record_play_top #(
        .BUFFER_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // looper state as the block should hold it
    logic [15:0] take_mem [DEPTH];
    bit          rec_on;
    longint      head_pos;
    longint      loop_len;
    bit          trig_high;
    longint      rate_step;
    bit          trig_conn;
    longint      trig_lvl;

    logic [15:0] expected_out [$];
    int          n_errors    = 0;
    int          items_sent  = 0;
    int          tx_idle_pct = IDLE_PCT;
    int          rx_idle_pct = IDLE_PCT;
    int          hold_req    = 0;
    int          hold_left   = 0;
    int          cycle_count = 0;

    function automatic logic [15:0] loop_output(input logic [15:0] audio,
                                                input logic [15:0] trig);
        longint trig_v, idx, frac, s0, s1, sum, y, span, r;
        bit     high;
        trig_v = trig_conn ? longint'($signed(trig)) : trig_lvl;
        high   = trig_v > 0;
        if (!trig_high && high) begin
            if (rec_on)
                loop_len = (head_pos >> 16) % DEPTH;
            head_pos = 0;
            rec_on   = !rec_on;
        end
        trig_high = high;
        idx = (head_pos >> 16) % DEPTH;
        if (rec_on) begin
            take_mem[idx] = audio;
            head_pos = ((idx + 1) % DEPTH) << 16;
            return '0;
        end
        frac = head_pos & 65535;
        s0   = longint'($signed(take_mem[idx]));
        s1   = longint'($signed(take_mem[(idx + 1) % DEPTH]));
        sum  = (65536 - frac) * s0 + frac * s1;
        // round to nearest, halves up
        y    = (sum + 32768) >>> 16;
        span = (loop_len > 0) ? loop_len : DEPTH;
        r    = (head_pos + rate_step) % (span * 65536);
        if (r < 0)
            r += span * 65536;
        head_pos = r;
        return y[15:0];
    endfunction

    function automatic logic [15:0] quiet_trig();
        return 16'(-int'($urandom_range(32768)));
    endfunction

    function automatic logic [15:0] rising_trig();
        return 16'($urandom_range(32767, 1));
    endfunction

    function automatic logic [CFG_DW-1:0] pick_rate();
        case ($urandom_range(5))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2:       return 24'h010000;
            3:       return 24'hFF0000;
            4:       return 24'(int'($urandom_range(262144)) - 131072);
            default: return 24'($urandom);
        endcase
    endfunction

    // check each output transaction against the oldest expected sample
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_out.size() == 0) begin
                n_errors++;
                if (n_errors <= SHOW_MAX)
                    $display("unexpected audio_out %h", m_axis_tdata);
            end else begin
                want = expected_out.pop_front();
                if (m_axis_tdata !== want) begin
                    n_errors++;
                    if (n_errors <= SHOW_MAX)
                        $display("audio_out mismatch: expected %h, got %h",
                                 want, m_axis_tdata);
                end
            end
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(input logic [15:0] audio, input logic [15:0] trig);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {trig, audio};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        expected_out.push_back(loop_output(audio, trig));
        items_sent++;
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        drain_outputs();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PLAYBACK_RATE:     rate_step = longint'($signed(val));
            CFG_TRIGGER_CONNECTED: trig_conn = val[0];
            CFG_TRIGGER_LEVEL:     trig_lvl  = longint'($signed(val[15:0]));
            default: ;
        endcase
    endtask

    // low, rise, take of len samples, rise to stop, then plays
    task automatic run_take(input int len, input int plays, input int noise_pct);
        send_item(16'($urandom), quiet_trig());
        send_item(16'($urandom), rising_trig());
        repeat (len - 1)
            send_item(16'($urandom),
                      ($urandom_range(99) < noise_pct) ? 16'($urandom) : quiet_trig());
        send_item(16'($urandom), rising_trig());
        repeat (plays)
            send_item(16'($urandom),
                      ($urandom_range(99) < noise_pct) ? 16'($urandom) : quiet_trig());
    endtask

    task automatic test_reset_state();
        // level mode at level zero: no edge, empty store plays silence
        send_item(16'h7FFF, 16'h8000);
        send_item(16'h8000, 16'h7FFF);
        send_item(16'hFFFF, 16'h0000);
    endtask

    task automatic test_record_take();
        write_reg(CFG_TRIGGER_CONNECTED, 24'h000001);
        send_item(16'h7FFF, 16'h0001);
        send_item(16'h8000, 16'h7FFF);
        send_item(16'h0000, 16'h0000);
        send_item(16'hFFFF, 16'h8000);
        // second rise ends the take: loop of four
        send_item(16'h1234, 16'h4000);
        repeat (5) send_item(16'($urandom), 16'hFFFF);
    endtask

    task automatic test_rate_extremes();
        // half step lands midway between samples: tests rounding of halves
        write_reg(CFG_PLAYBACK_RATE, 24'h008000);
        repeat (2) send_item(16'($urandom), 16'h8000);
        write_reg(CFG_PLAYBACK_RATE, 24'h800000);
        repeat (2) send_item(16'($urandom), 16'h8000);
        write_reg(CFG_PLAYBACK_RATE, 24'h7FFFFF);
        repeat (2) send_item(16'($urandom), 16'h8000);
        write_reg(CFG_PLAYBACK_RATE, 24'h000000);
        repeat (2) send_item(16'($urandom), 16'h8000);
    endtask

    task automatic test_level_trigger();
        write_reg(CFG_TRIGGER_CONNECTED, 24'hFFFFFE);
        write_reg(CFG_TRIGGER_LEVEL, 24'h007FFF);
        send_item(16'h7FFF, 16'h8000);
        send_item(16'h8000, 16'h8000);
        write_reg(CFG_TRIGGER_LEVEL, 24'hFF8000);
        send_item(16'h5555, 16'h7FFF);
        write_reg(CFG_TRIGGER_LEVEL, 24'h000001);
        send_item(16'hAAAA, 16'h0000);
    endtask

    task automatic test_output_stall();
        write_reg(CFG_TRIGGER_CONNECTED, 24'h000001);
        write_reg(CFG_PLAYBACK_RATE, 24'h010000);
        tx_idle_pct = 0;
        hold_req    = HOLD_CYCLES;
        repeat (40) send_item(16'($urandom), quiet_trig());
        tx_idle_pct = IDLE_PCT;
    endtask

    task automatic test_loop_end_neighbour();
        // a short take over a longer one: the neighbour read at the loop end
        // comes from the older take, not from the loop start
        write_reg(CFG_TRIGGER_CONNECTED, 24'h000001);
        write_reg(CFG_PLAYBACK_RATE, 24'h010000);
        run_take(40, 4, 0);
        // reverse half step wraps from the loop start to just before its end
        write_reg(CFG_PLAYBACK_RATE, 24'hFF8000);
        run_take(8, 30, 0);
        write_reg(CFG_PLAYBACK_RATE, 24'h7FFFFF);
        repeat (30) send_item(16'($urandom), quiet_trig());
    endtask

    task automatic test_random_phases();
        int start;
        int phase;
        int kind;
        int len;
        int plays;
        start = items_sent;
        phase = 0;
        while (items_sent - start < 760) begin
            if (phase == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (phase == 16) begin
                tx_idle_pct = IDLE_PCT;
                rx_idle_pct = IDLE_PCT;
            end
            write_reg(CFG_PLAYBACK_RATE, pick_rate());
            kind = $urandom_range(99);
            if (kind < 15) begin
                write_reg(CFG_TRIGGER_CONNECTED, {23'($urandom), 1'b0});
                write_reg(CFG_TRIGGER_LEVEL, 24'($urandom));
                repeat ($urandom_range(30, 10))
                    send_item(16'($urandom), 16'($urandom));
            end else begin
                write_reg(CFG_TRIGGER_CONNECTED, {23'($urandom), 1'b1});
                if (kind < 30) begin
                    repeat ($urandom_range(30, 10))
                        send_item(16'($urandom), 16'($urandom));
                end else begin
                    len   = ($urandom_range(9) == 0) ? $urandom_range(200, 41)
                                                     : $urandom_range(40, 1);
                    plays = ($urandom_range(9) == 0) ? 150 : $urandom_range(50, 4);
                    run_take(len, plays, 5);
                end
            end
            phase++;
        end
    endtask

    initial begin
        foreach (take_mem[k])
            take_mem[k] = '0;
        rec_on    = 1'b0;
        head_pos  = 0;
        loop_len  = 0;
        trig_high = 1'b0;
        rate_step = longint'($signed(RATE_RESET));
        trig_conn = 1'b0;
        trig_lvl  = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_record_take();
        test_rate_extremes();
        test_level_trigger();
        test_output_stall();
        test_loop_end_neighbour();
        test_random_phases();

        drain_outputs();
        if (n_errors == 0 && expected_out.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: audio_looper_record_play_top.f
rtl/alr_pkg.sv
rtl/alr_ram.sv
rtl/alr_rate_wrap.sv
rtl/audio_looper_record_play_top.sv
sim/tb_top.sv
